// File: rtl/sha256_pkg.sv
// Shared constants and types for the SHA-256 stream hasher.
// Depends on nothing; the core and top-level files use it by scoped names.
package sha256_pkg;

    localparam int unsigned WordW  = 32;
    localparam int unsigned Rounds = 64;
    localparam logic [7:0]  PadByte = 8'h80;

    typedef logic [WordW-1:0] word_t;
    typedef word_t [7:0] hash_t;

    localparam hash_t InitHash = '{
        32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
        32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
    };

    // Round constant for round t
    function automatic word_t round_k(input logic [5:0] t);
        word_t k;
        begin
            case (t)
                6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491;
                6'd2: k = 32'hb5c0fbcf; 6'd3: k = 32'he9b5dba5;
                6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
                6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5;
                6'd8: k = 32'hd807aa98; 6'd9: k = 32'h12835b01;
                6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
                6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe;
                6'd14: k = 32'h9bdc06a7; 6'd15: k = 32'hc19bf174;
                6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
                6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc;
                6'd20: k = 32'h2de92c6f; 6'd21: k = 32'h4a7484aa;
                6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
                6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d;
                6'd26: k = 32'hb00327c8; 6'd27: k = 32'hbf597fc7;
                6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
                6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967;
                6'd32: k = 32'h27b70a85; 6'd33: k = 32'h2e1b2138;
                6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
                6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb;
                6'd38: k = 32'h81c2c92e; 6'd39: k = 32'h92722c85;
                6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
                6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3;
                6'd44: k = 32'hd192e819; 6'd45: k = 32'hd6990624;
                6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
                6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08;
                6'd50: k = 32'h2748774c; 6'd51: k = 32'h34b0bcb5;
                6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
                6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3;
                6'd56: k = 32'h748f82ee; 6'd57: k = 32'h78a5636f;
                6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
                6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb;
                6'd62: k = 32'hbef9a3f7; default: k = 32'hc67178f2;
            endcase
            return k;
        end
    endfunction

    function automatic word_t ror(input word_t x, input int unsigned n);
        begin
            return (x >> n) | (x << (WordW - n));
        end
    endfunction

    // Control from sequencer to compression core
    typedef struct packed {
        logic start;
        logic init;
    } core_ctl_t;

endpackage

// File: rtl/sha256_core.sv
// One-round-per-cycle SHA-256 compression unit with a 16-word schedule window.
// Depends on sha256_pkg.
module sha256_core
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  sha256_pkg::core_ctl_t       ctl,
    input  sha256_pkg::word_t [15:0]    block,
    output logic                        busy,
    output sha256_pkg::hash_t           hash
);

    sha256_pkg::hash_t       hash_reg, v_reg;
    sha256_pkg::word_t [15:0] w_reg;
    logic [5:0] t_reg;
    logic       busy_reg;

    sha256_pkg::word_t e, a, t1, t2, s0, s1, wn;

    // Single round datapath and schedule step
    always_comb
    begin
        e  = v_reg[4];
        a  = v_reg[0];
        t1 = v_reg[7] + (sha256_pkg::ror(e, 6) ^ sha256_pkg::ror(e, 11)
             ^ sha256_pkg::ror(e, 25)) + ((e & v_reg[5]) ^ (~e & v_reg[6]))
             + sha256_pkg::round_k(t_reg) + w_reg[0];
        t2 = (sha256_pkg::ror(a, 2) ^ sha256_pkg::ror(a, 13) ^ sha256_pkg::ror(a, 22))
             + ((a & v_reg[1]) ^ (a & v_reg[2]) ^ (v_reg[1] & v_reg[2]));
        s0 = sha256_pkg::ror(w_reg[1], 7) ^ sha256_pkg::ror(w_reg[1], 18)
             ^ (w_reg[1] >> 3);
        s1 = sha256_pkg::ror(w_reg[14], 17) ^ sha256_pkg::ror(w_reg[14], 19)
             ^ (w_reg[14] >> 10);
        wn = s1 + w_reg[9] + s0 + w_reg[0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            t_reg    <= '0;
            hash_reg <= sha256_pkg::InitHash;
            v_reg    <= '0;
            w_reg    <= '0;
        end
        else if (ctl.init)
        begin
            hash_reg <= sha256_pkg::InitHash;
        end
        else if (ctl.start)
        begin
            busy_reg <= 1'b1;
            t_reg    <= '0;
            v_reg    <= hash_reg;
            w_reg    <= block;
        end
        else if (busy_reg)
        begin
            // advance one round
            v_reg <= {v_reg[6:4], v_reg[3] + t1, v_reg[2:0], t1 + t2};
            w_reg <= {wn, w_reg[15:1]};
            t_reg <= t_reg + 6'd1;
            if (t_reg == 6'(sha256_pkg::Rounds - 1))
            begin
                busy_reg    <= 1'b0;
                hash_reg[0] <= hash_reg[0] + t1 + t2;
                for (int i = 1; i < 8; i++)
                begin
                    if (i == 4)
                        hash_reg[i] <= hash_reg[i] + v_reg[3] + t1;
                    else
                        hash_reg[i] <= hash_reg[i] + v_reg[i-1];
                end
            end
        end
    end

    assign busy = busy_reg;
    assign hash = hash_reg;

endmodule

// File: rtl/sha256_stream_hasher_unit.sv
// SHA-256 stream hasher top level: byte packer, padding sequencer, digest out.
// Flow: a byte that does not complete a block is taken without holding off input; a byte that
// completes one holds off input while the block is compressed (start, 64 rounds, handoff). An end item
// pads one byte per cycle up to the block end, runs one or two such compressions,
// then shows eight digest words.
// Reset: asynchronous active low; hash returns to the initial value, counts clear.
module sha256_stream_hasher_unit
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic [1:0]  s_tuser,   // [0] byte_present, [1] end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] digest_word, [34:32] word_index, rest 0
    output logic        m_tlast    // final_word
);

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_COMP = 5'b00010,
        ST_PAD  = 5'b00100,
        ST_WAIT = 5'b01000,
        ST_OUT  = 5'b10000
    } state_t;

    state_t state_reg, state_next;
    logic [511:0] blk_reg;         // byte shift line, oldest byte on top
    logic [5:0]   fill_reg;
    logic [60:0]  total_reg;
    logic [2:0]   idx_reg;
    logic         last_reg;        // compression in flight is the final one
    logic         pend_reg;        // end flag still to handle
    logic         pad_first_reg;   // 0x80 still to place
    logic         final_blk_reg;   // block being filled carries the length
    sha256_pkg::word_t [15:0] block;
    sha256_pkg::core_ctl_t    ctl;
    logic busy;
    sha256_pkg::hash_t hash;
    logic [63:0] bits;
    logic [7:0]  pad_byte;

    // Split the byte line into big-endian words, word 0 first
    always_comb
    begin
        for (int i = 0; i < 16; i++)
            block[i] = blk_reg[32*(15-i) +: 32];
    end

    assign bits = {total_reg, 3'b000};

    // Pick the padding byte for the current offset
    always_comb
    begin
        if (pad_first_reg)
            pad_byte = sha256_pkg::PadByte;
        else if (final_blk_reg && fill_reg >= 6'd56)
            pad_byte = bits[{~fill_reg[2:0], 3'b000} +: 8];
        else
            pad_byte = 8'h00;
    end

    sha256_core u_core
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (ctl),
        .block (block),
        .busy  (busy),
        .hash  (hash)
    );

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {5'd0, idx_reg, hash[idx_reg]};
    assign m_tlast  = (idx_reg == 3'd7);

    // Sequencer next state
    always_comb
    begin
        state_next = state_reg;
        ctl = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    if (s_tuser[0] && fill_reg == 6'd63)
                        state_next = ST_COMP;
                    else if (s_tuser[1])
                        state_next = ST_PAD;
                end
            end
            ST_COMP:
            begin
                ctl.start  = 1'b1;
                state_next = ST_WAIT;
            end
            ST_PAD:
            begin
                // one byte of padding per cycle up to the block end
                if (fill_reg == 6'd63)
                    state_next = ST_COMP;
            end
            ST_WAIT:
            begin
                if (!busy)
                begin
                    if (last_reg)
                        state_next = ST_OUT;
                    else if (pend_reg)
                        state_next = ST_PAD;
                    else
                        state_next = ST_IDLE;
                end
            end
            ST_OUT:
            begin
                if (m_tready && idx_reg == 3'd7)
                begin
                    ctl.init   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Shift message and padding bytes into the block line
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && s_tvalid && s_tuser[0])
            blk_reg <= {blk_reg[503:0], s_tdata};
        else if (state_reg == ST_PAD)
            blk_reg <= {blk_reg[503:0], pad_byte};
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fill_reg      <= '0;
            total_reg     <= '0;
            idx_reg       <= '0;
            last_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            pad_first_reg <= 1'b0;
            final_blk_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        pend_reg      <= s_tuser[1];
                        pad_first_reg <= 1'b1;
                        final_blk_reg <= 1'b0;
                        if (s_tuser[0])
                        begin
                            total_reg <= total_reg + 61'd1;
                            fill_reg  <= fill_reg + 6'd1;
                        end
                    end
                end
                ST_COMP: last_reg <= final_blk_reg;
                ST_PAD:
                begin
                    fill_reg      <= fill_reg + 6'd1;
                    pad_first_reg <= 1'b0;
                    if (pad_first_reg && fill_reg < 6'd56)
                        final_blk_reg <= 1'b1;
                end
                ST_WAIT:
                begin
                    // 0x80 went into the previous block: this one carries the length
                    if (!busy && !last_reg && pend_reg && !pad_first_reg)
                        final_blk_reg <= 1'b1;
                end
                ST_OUT:
                begin
                    if (m_tready)
                    begin
                        idx_reg <= idx_reg + 3'd1;
                        if (idx_reg == 3'd7)
                        begin
                            fill_reg  <= '0;
                            total_reg <= '0;
                            pend_reg  <= 1'b0;
                            last_reg  <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

endmodule

// File: rtl/sha256_checker.sv
// Port-level checks for the SHA-256 stream hasher.
// Depends on sha256_stream_hasher_unit ports; bound to the top level below.
module sha256_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata,
    input logic        m_tlast
);

    // no input taken while a digest is shown
    a_excl: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready) else $error("input ready during output");

    // last flag only on word seven
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tlast == (m_tdata[34:32] == 3'd7)))
        else $error("tlast mismatch");

    // index advances after each taken word but the last
    a_idx: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=>
        (m_tvalid && m_tdata[34:32] == $past(m_tdata[34:32]) + 3'd1))
        else $error("index skip");

    // stalled word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("output changed under stall");

endmodule

bind sha256_stream_hasher_unit sha256_checker u_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
